// ===== rtl/midi_to_pitch_cv_with_glide_defines.svh =====
// assertion macros shared by the converter rtl
`ifndef MIDI_TO_PITCH_CV_WITH_GLIDE_DEFINES_SVH
`define MIDI_TO_PITCH_CV_WITH_GLIDE_DEFINES_SVH

// same-cycle implication on clk, disabled in reset
`define MTCV_ASSERT_NOW(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("mtcv same-cycle check failed");

// next-cycle implication on clk, disabled in reset
`define MTCV_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("mtcv next-cycle check failed");

`endif

// ===== rtl/mtcv_pkg.sv =====
// types, constants and helper functions of the midi to pitch cv converter
`default_nettype none

package mtcv_pkg;

    // fixed widths
    localparam int FREQ_W = 40;
    localparam int NUM_W  = 60;
    localparam int DEN_W  = 42;
    localparam int BEND_W = 18;
    localparam int CFG_W  = 24;

    // configuration register indexes
    localparam logic [2:0] CFG_CHANNEL   = 3'd0;
    localparam logic [2:0] CFG_GLIDE_MD  = 3'd1;
    localparam logic [2:0] CFG_GLIDE_US  = 3'd2;
    localparam logic [2:0] CFG_BEND_RNG  = 3'd3;
    localparam logic [2:0] CFG_AT_MODE   = 3'd4;
    localparam logic [2:0] CFG_SRATE     = 3'd5;

    // midi message types (upper nibble of status)
    localparam logic [3:0] MSG_NOTE_OFF   = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON    = 4'h9;
    localparam logic [3:0] MSG_POLY_PRESS = 4'hA;
    localparam logic [3:0] MSG_CHAN_PRESS = 4'hD;
    localparam logic [3:0] MSG_BEND       = 4'hE;

    // result target codes
    localparam logic [2:0] TGT_TELEM = 3'd0;
    localparam logic [2:0] TGT_FREQ  = 3'd1;
    localparam logic [2:0] TGT_GATE  = 3'd2;
    localparam logic [2:0] TGT_VEL   = 3'd3;
    localparam logic [2:0] TGT_PRESS = 3'd4;

    // numeric constants
    localparam logic [FREQ_W-1:0] FREQ_MAX   = {FREQ_W{1'b1}};
    localparam logic [FREQ_W-1:0] HZ440      = 40'd7381975040;
    localparam logic [FREQ_W-1:0] RATE_STEP  = 40'd16777216;
    localparam logic [BEND_W-1:0] BEND_UNITY = 18'd65536;
    localparam logic [BEND_W-1:0] BEND_OFS   = 18'd19660;
    localparam logic [21:0]       BEND_BIAS  = 22'd688140;
    localparam logic [22:0]       RECIP30    = 23'd4473925;
    localparam logic [19:0]       MICRO      = 20'd1000000;
    localparam logic [7:0]        RECIP12    = 8'd171;
    localparam logic [31:0]       LEVEL_ONE  = 32'd65536;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  status_byte;
        logic [6:0]  data_one;
        logic [6:0]  data_two;
        logic [12:0] block_length;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  target;
        logic [31:0] level;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        KIND_DROP, KIND_NOTE_ON, KIND_NOTE_OFF, KIND_BEND,
        KIND_PRESS, KIND_OTHER, KIND_AUDIO
    } kind_t;

    typedef enum logic [2:0] {
        RES_TELEM, RES_FREQ, RES_GATE_ON, RES_GATE_OFF, RES_VEL, RES_PRESS
    } res_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_BEND_DIV, ST_BEND_SET, ST_TGT_MUL, ST_TGT_SET,
        ST_STEP_PREP, ST_STEP_MUL, ST_STEP_SUM, ST_DIV_START, ST_DIV_WAIT,
        ST_STEP_SET, ST_BLK_MUL, ST_BLK_SET, ST_EMIT_TELEM, ST_EMIT_FREQ,
        ST_EMIT_VEL, ST_EMIT_GATE, ST_EMIT_PRESS
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic base_set;
        logic bend_mul;
        logic bend_div;
        logic bend_set;
        logic tgt_mul;
        logic tgt_set;
        logic step_prep;
        logic step_mul;
        logic step_sum;
        logic div_start;
        logic step_set;
        logic blk_mul;
        logic blk_set;
        logic emit;
        res_t res;
        logic last;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        kind_t kind;
        logic  glide_off;
        logic  glide_rate;
        logic  cur_eq_tgt;
        logic  den_zero;
        logic  div_done;
        logic  out_free;
    } dp_stat_t;

    // semitone table, Q4.24, lowest octave
    function automatic logic [27:0] semi_freq(input logic [3:0] idx);
        logic [27:0] f;
        unique case (idx)
            4'd0:    f = 28'd137167144;
            4'd1:    f = 28'd145323527;
            4'd2:    f = 28'd153964914;
            4'd3:    f = 28'd163120144;
            4'd4:    f = 28'd172819773;
            4'd5:    f = 28'd183096171;
            4'd6:    f = 28'd193983636;
            4'd7:    f = 28'd205518503;
            4'd8:    f = 28'd217739269;
            4'd9:    f = 28'd230686720;
            4'd10:   f = 28'd244404066;
            4'd11:   f = 28'd258937088;
            default: f = 28'd0;
        endcase
        return f;
    endfunction

    // round(d * 65536 / 127): d*516 plus (4d + 63) / 127
    function automatic logic [31:0] scale127(input logic [6:0] d);
        logic [9:0] t;
        logic [2:0] q;
        t = {1'b0, d, 2'b00} + 10'd63;
        q = {2'b00, t >= 10'd127} + {2'b00, t >= 10'd254}
          + {2'b00, t >= 10'd381} + {2'b00, t >= 10'd508};
        return 32'({d, 9'b0}) + 32'({d, 2'b0}) + 32'(q);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mtcv_div.sv =====
// restoring divider for the glide step, one quotient bit per cycle
`default_nettype none

module mtcv_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [mtcv_pkg::NUM_W-1:0] num,
    input  wire logic [mtcv_pkg::DEN_W-1:0] den,
    output logic                            done,
    output logic [mtcv_pkg::NUM_W-1:0]      quo
);
    import mtcv_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W-1:0] rem_next;

    // one trial subtract
    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(NUM_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != CNT_W'(1);
            done_reg <= cnt_reg == CNT_W'(1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/mtcv_datapath.sv =====
// datapath: configuration, frequency state, multipliers, divider, result register
`default_nettype none

module mtcv_datapath #(
    parameter int MAX_BLOCK = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [23:0]          cfg_data,
    input  wire mtcv_pkg::in_item_t   in_item,
    input  wire mtcv_pkg::dp_cmd_t    cmd,
    output mtcv_pkg::dp_stat_t        stat,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output mtcv_pkg::out_item_t       out_item
);
    import mtcv_pkg::*;

    // configuration registers
    logic [4:0]  chan_sel_reg;
    logic        glide_md_reg;
    logic [23:0] glide_us_reg;
    logic [3:0]  bend_rng_reg;
    logic        at_mode_reg;
    logic [17:0] srate_reg;

    // frequency state
    logic [FREQ_W-1:0] base_reg, target_reg, current_reg;
    logic [BEND_W-1:0] bend_reg;
    logic [FREQ_W-1:0] step_mag_reg;
    logic              step_neg_reg;

    // working registers
    in_item_t          item_reg;
    logic signed [21:0] bprod_reg;
    logic [44:0]       recip_reg;
    logic [39:0]       pa_reg, pb_reg;
    logic [FREQ_W-1:0] dmag_reg;
    logic              dneg_reg, dup_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  num_reg;

    // result register
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic              div_done;
    logic [NUM_W-1:0]  div_quo;

    mtcv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // message classification
    logic [4:0] chan;
    logic       chan_pass;
    kind_t      kind;
    always_comb
    begin
        chan      = {1'b0, item_reg.status_byte[3:0]} + 5'd1;
        chan_pass = (chan_sel_reg == 5'd0) || (chan_sel_reg == chan);
        kind      = KIND_OTHER;
        if (item_reg.opcode)
            kind = KIND_AUDIO;
        else if (!chan_pass)
            kind = KIND_DROP;
        else
        begin
            unique case (item_reg.status_byte[7:4])
                MSG_NOTE_ON:    kind = (item_reg.data_two != 7'd0) ? KIND_NOTE_ON
                                                                    : KIND_NOTE_OFF;
                MSG_NOTE_OFF:   kind = KIND_NOTE_OFF;
                MSG_BEND:       kind = KIND_BEND;
                MSG_CHAN_PRESS: kind = at_mode_reg ? KIND_OTHER : KIND_PRESS;
                MSG_POLY_PRESS: kind = at_mode_reg ? KIND_PRESS : KIND_OTHER;
                default:        kind = KIND_OTHER;
            endcase
        end
    end

    // status to the controller
    always_comb
    begin
        stat.kind       = kind;
        stat.glide_off  = glide_us_reg <= 24'd1;
        stat.glide_rate = glide_md_reg;
        stat.cur_eq_tgt = current_reg == target_reg;
        stat.den_zero   = den_reg == '0;
        stat.div_done   = div_done;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // note number to octave and semitone
    logic [14:0]       note_prod;
    logic [3:0]        octave;
    logic [6:0]        semi;
    logic [FREQ_W-1:0] base_next;
    always_comb
    begin
        note_prod = 15'(item_reg.data_one * RECIP12);
        octave    = note_prod[14:11];
        semi      = item_reg.data_one - 7'({octave, 3'b0} + {1'b0, octave, 2'b0});
        base_next = {12'd0, semi_freq(semi[3:0])} << octave;
    end

    // pitch bend: (b*range*7 + bias) then reciprocal divide by thirty
    logic [3:0]         range_sat;
    logic [6:0]         range7;
    logic signed [21:0] b_ext, r_ext;
    logic [21:0]        bend_u, bend_x;
    always_comb
    begin
        range_sat = (bend_rng_reg > 4'd12) ? 4'd12 : bend_rng_reg;
        range7    = 7'({range_sat, 3'b0} - {3'b0, range_sat});
        b_ext     = 22'(signed'({~item_reg.data_two[6], item_reg.data_two[5:0],
                                 item_reg.data_one}));
        r_ext     = {15'd0, range7};
        bend_u    = 22'(bprod_reg) + BEND_BIAS;
        bend_x    = {bend_u[20:0], 1'b0} + 22'd15;
    end

    // target from partial products
    logic [59:0] tgt_full;
    assign tgt_full = {pb_reg, 20'b0} + {20'b0, pa_reg};

    // step magnitude from quotient
    logic [FREQ_W-1:0] q_cap, q_fix;
    always_comb
    begin
        q_cap = (div_quo[NUM_W-1:FREQ_W] != '0) ? FREQ_MAX : div_quo[FREQ_W-1:0];
        q_fix = stat.den_zero ? dmag_reg : q_cap;
        if (q_fix == '0 && dmag_reg != '0)
            q_fix = FREQ_W'(1);
    end

    // block length clamp
    logic [12:0] blk_n;
    assign blk_n = ({19'd0, item_reg.block_length} > 32'(MAX_BLOCK)) ? 13'(MAX_BLOCK)
                                                                     : item_reg.block_length;

    // audio block move toward the target
    logic [52:0]       blk_mag;
    logic [53:0]       cur_w, tgt_w, up_sum;
    logic [FREQ_W-1:0] cur_next;
    always_comb
    begin
        blk_mag = {pb_reg[32:0], 20'b0} + {20'b0, pa_reg[32:0]};
        cur_w   = {14'd0, current_reg};
        tgt_w   = {14'd0, target_reg};
        up_sum  = cur_w + {1'b0, blk_mag};
        if (!step_neg_reg)
        begin
            if (current_reg < target_reg && up_sum > tgt_w)
                cur_next = target_reg;
            else if (up_sum > {14'd0, FREQ_MAX})
                cur_next = FREQ_MAX;
            else
                cur_next = up_sum[FREQ_W-1:0];
        end
        else
        begin
            if ({1'b0, blk_mag} >= cur_w)
                cur_next = '0;
            else
                cur_next = current_reg - blk_mag[FREQ_W-1:0];
            if (current_reg > target_reg && cur_next < target_reg)
                cur_next = target_reg;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_sel_reg <= 5'd0;
            glide_md_reg <= 1'b0;
            glide_us_reg <= 24'd0;
            bend_rng_reg <= 4'd2;
            at_mode_reg  <= 1'b0;
            srate_reg    <= 18'd44100;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CHANNEL:  chan_sel_reg <= cfg_data[4:0];
                CFG_GLIDE_MD: glide_md_reg <= cfg_data[0];
                CFG_GLIDE_US: glide_us_reg <= cfg_data;
                CFG_BEND_RNG: bend_rng_reg <= cfg_data[3:0];
                CFG_AT_MODE:  at_mode_reg  <= cfg_data[0];
                CFG_SRATE:    srate_reg    <= cfg_data[17:0];
                default:      ;
            endcase
        end
    end

    // frequency state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= HZ440;
            target_reg   <= HZ440;
            current_reg  <= HZ440;
            bend_reg     <= BEND_UNITY;
            step_mag_reg <= '0;
            step_neg_reg <= 1'b0;
        end
        else
        begin
            if (cmd.base_set)
                base_reg <= base_next;
            if (cmd.bend_set)
                bend_reg <= recip_reg[44:27] + BEND_OFS;
            if (cmd.tgt_set)
            begin
                target_reg <= tgt_full[55:16];
                if (stat.glide_off)
                    current_reg <= tgt_full[55:16];
            end
            if (cmd.step_set)
            begin
                step_mag_reg <= glide_md_reg ? RATE_STEP : q_fix;
                step_neg_reg <= glide_md_reg ? !dup_reg : dneg_reg;
            end
            if (cmd.blk_set)
                current_reg <= cur_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_item;
        if (cmd.bend_mul)
            bprod_reg <= b_ext * r_ext;
        if (cmd.bend_div)
            recip_reg <= 45'(bend_x) * 45'(RECIP30);
        if (cmd.tgt_mul)
        begin
            pa_reg <= 40'(base_reg[19:0] * bend_reg);
            pb_reg <= 40'(base_reg[39:20] * bend_reg);
        end
        if (cmd.step_prep)
        begin
            dneg_reg <= target_reg < current_reg;
            dup_reg  <= target_reg > current_reg;
            dmag_reg <= (target_reg < current_reg) ? current_reg - target_reg
                                                   : target_reg - current_reg;
            den_reg  <= DEN_W'(glide_us_reg * srate_reg);
        end
        if (cmd.step_mul)
        begin
            pa_reg <= 40'(dmag_reg[19:0] * MICRO);
            pb_reg <= 40'(dmag_reg[39:20] * MICRO);
        end
        if (cmd.step_sum)
            num_reg <= {pb_reg, 20'b0} + {20'b0, pa_reg};
        if (cmd.blk_mul)
        begin
            pa_reg <= 40'(step_mag_reg[19:0] * blk_n);
            pb_reg <= 40'(step_mag_reg[39:20] * blk_n);
        end
    end

    // result level select
    out_item_t res_item;
    always_comb
    begin
        res_item.last = cmd.last;
        unique case (cmd.res)
            RES_TELEM:
            begin
                res_item.target = TGT_TELEM;
                res_item.level  = LEVEL_ONE;
            end
            RES_FREQ:
            begin
                res_item.target = TGT_FREQ;
                res_item.level  = current_reg[39:8];
            end
            RES_GATE_ON:
            begin
                res_item.target = TGT_GATE;
                res_item.level  = LEVEL_ONE;
            end
            RES_GATE_OFF:
            begin
                res_item.target = TGT_GATE;
                res_item.level  = '0;
            end
            RES_VEL:
            begin
                res_item.target = TGT_VEL;
                res_item.level  = scale127(item_reg.data_two);
            end
            RES_PRESS:
            begin
                res_item.target = TGT_PRESS;
                res_item.level  = scale127(at_mode_reg ? item_reg.data_two
                                                       : item_reg.data_one);
            end
            default:
            begin
                res_item.target = TGT_TELEM;
                res_item.level  = '0;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_item_reg <= res_item;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== rtl/mtcv_ctrl.sv =====
// controller: sequences decode, arithmetic steps and result transfers
`default_nettype none

module mtcv_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    idle,
    input  wire mtcv_pkg::dp_stat_t stat,
    output mtcv_pkg::dp_cmd_t       cmd
);
    import mtcv_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_DECODE;
            ST_DECODE:
            begin
                unique case (stat.kind)
                    KIND_DROP:    state_next = ST_IDLE;
                    KIND_AUDIO:   state_next = stat.cur_eq_tgt ? ST_IDLE : ST_BLK_MUL;
                    KIND_NOTE_ON: state_next = ST_TGT_MUL;
                    KIND_BEND:    state_next = ST_BEND_DIV;
                    default:      state_next = ST_EMIT_TELEM;
                endcase
            end
            ST_BEND_DIV:  state_next = ST_BEND_SET;
            ST_BEND_SET:  state_next = ST_TGT_MUL;
            ST_TGT_MUL:   state_next = ST_TGT_SET;
            ST_TGT_SET:
                state_next = (stat.kind == KIND_NOTE_ON && !stat.glide_off) ? ST_STEP_PREP
                                                                            : ST_EMIT_TELEM;
            ST_STEP_PREP: state_next = ST_STEP_MUL;
            ST_STEP_MUL:  state_next = ST_STEP_SUM;
            ST_STEP_SUM:
                state_next = (!stat.glide_rate && !stat.den_zero) ? ST_DIV_START
                                                                  : ST_STEP_SET;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (stat.div_done)
                    state_next = ST_STEP_SET;
            ST_STEP_SET:  state_next = ST_EMIT_TELEM;
            ST_BLK_MUL:   state_next = ST_BLK_SET;
            ST_BLK_SET:   state_next = ST_EMIT_FREQ;
            ST_EMIT_TELEM:
                if (stat.out_free)
                begin
                    unique case (stat.kind)
                        KIND_NOTE_ON:  state_next = stat.glide_off ? ST_EMIT_FREQ
                                                                   : ST_EMIT_VEL;
                        KIND_NOTE_OFF: state_next = ST_EMIT_GATE;
                        KIND_BEND:     state_next = stat.glide_off ? ST_EMIT_FREQ
                                                                   : ST_IDLE;
                        KIND_PRESS:    state_next = ST_EMIT_PRESS;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            ST_EMIT_FREQ:
                if (stat.out_free)
                    state_next = (stat.kind == KIND_NOTE_ON) ? ST_EMIT_VEL : ST_IDLE;
            ST_EMIT_VEL:
                if (stat.out_free)
                    state_next = ST_EMIT_GATE;
            ST_EMIT_GATE, ST_EMIT_PRESS:
                if (stat.out_free)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        cmd.res  = RES_TELEM;
        idle     = state_reg == ST_IDLE;
        unique case (state_reg)
            ST_IDLE:      cmd.load = in_valid;
            ST_DECODE:
            begin
                cmd.base_set = stat.kind == KIND_NOTE_ON;
                cmd.bend_mul = stat.kind == KIND_BEND;
            end
            ST_BEND_DIV:  cmd.bend_div  = 1'b1;
            ST_BEND_SET:  cmd.bend_set  = 1'b1;
            ST_TGT_MUL:   cmd.tgt_mul   = 1'b1;
            ST_TGT_SET:   cmd.tgt_set   = 1'b1;
            ST_STEP_PREP: cmd.step_prep = 1'b1;
            ST_STEP_MUL:  cmd.step_mul  = 1'b1;
            ST_STEP_SUM:  cmd.step_sum  = 1'b1;
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_DIV_WAIT:  ;
            ST_STEP_SET:  cmd.step_set  = 1'b1;
            ST_BLK_MUL:   cmd.blk_mul   = 1'b1;
            ST_BLK_SET:   cmd.blk_set   = 1'b1;
            ST_EMIT_TELEM:
            begin
                cmd.emit = stat.out_free;
                cmd.res  = RES_TELEM;
                cmd.last = stat.kind == KIND_OTHER
                        || (stat.kind == KIND_BEND && !stat.glide_off);
            end
            ST_EMIT_FREQ:
            begin
                cmd.emit = stat.out_free;
                cmd.res  = RES_FREQ;
                cmd.last = stat.kind != KIND_NOTE_ON;
            end
            ST_EMIT_VEL:
            begin
                cmd.emit = stat.out_free;
                cmd.res  = RES_VEL;
            end
            ST_EMIT_GATE:
            begin
                cmd.emit = stat.out_free;
                cmd.res  = (stat.kind == KIND_NOTE_ON) ? RES_GATE_ON : RES_GATE_OFF;
                cmd.last = 1'b1;
            end
            ST_EMIT_PRESS:
            begin
                cmd.emit = stat.out_free;
                cmd.res  = RES_PRESS;
                cmd.last = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/midi_to_pitch_cv_with_glide.sv =====
// top level of the monophonic midi to pitch cv converter with glide
//
//   channel  | signals                          | transfer when
//   ---------+----------------------------------+-----------------------
//   input    | in_valid, in_ready, in_item      | in_valid & in_ready
//   output   | out_valid, out_ready, out_item   | out_valid & out_ready
//   config   | cfg_write, cfg_index, cfg_data   | cfg_write
//
// one item at a time; in_ready is high only while the controller is idle
// midi messages pass through decode and their arithmetic states, then emit their results
// a note on in time glide mode also runs the step states and waits on the 60-step divider
// audio blocks pass the multiply and set states, then emit the frequency; none when nothing moves
// each result state waits while the output register holds an untaken result
// reset is asynchronous active low; no clearing pass is needed
`default_nettype none

module midi_to_pitch_cv_with_glide #(
    parameter int MAX_BLOCK = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [23:0]         cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire mtcv_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output mtcv_pkg::out_item_t      out_item
);
    import mtcv_pkg::*;

    `include "midi_to_pitch_cv_with_glide_defines.svh"

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     idle;

    mtcv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .idle     (idle),
        .stat     (stat),
        .cmd      (cmd)
    );

    mtcv_datapath #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    assign in_ready = idle;

    // a result is never loaded over one still waiting
    `MTCV_ASSERT_NOW(a_emit_free, cmd.emit, stat.out_free)
    // after the final result the block is ready again
    `MTCV_ASSERT_NEXT(a_last_idle, cmd.emit && cmd.last, in_ready)
    // an accepted item makes the block busy
    `MTCV_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire
